@@ rtl/scpf_pkg.sv @@
package scpf_pkg;

    // Field and register widths.
    localparam int AxisW    = 8;
    localparam int ForceW   = 8;
    localparam int VelW     = 9;
    localparam int GainW    = 7;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 8;

    typedef logic signed [AxisW-1:0]  t_axis;
    typedef logic signed [ForceW-1:0] t_force;
    typedef logic signed [VelW-1:0]   t_vel;
    typedef logic [GainW-1:0]         t_gain;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_SPRING_GAIN  = 8'd0,
        REG_DAMPING_GAIN = 8'd1,
        REG_DEAD_BAND    = 8'd2,
        REG_STICTION     = 8'd3
    } t_reg_idx;

    // Register values after reset.
    localparam t_gain SPRING_GAIN_RST  = 7'd10;
    localparam t_gain DAMPING_GAIN_RST = 7'd30;
    localparam t_gain DEAD_BAND_RST    = 7'd10;
    localparam t_gain STICTION_RST     = 7'd60;

    // Clamp limits of the force terms.
    localparam logic signed [16:0] P_LIM = 17'sd90;
    localparam logic signed [16:0] D_LIM = 17'sd127;
    localparam logic signed [9:0]  F_LIM = 10'sd127;

    // Per-lane pipeline controls driven by the top level.
    typedef struct packed {
        logic load_s1;
        logic upd_state;
        logic seeded;
        logic load_s2;
    } t_lane_ctl;

    // Halve a 9-bit signed value, truncating toward zero.
    function automatic logic signed [7:0] half_tz(input logic signed [8:0] a);
        logic signed [9:0] tmp;
        tmp = {a[8], a} + {9'b0, a[8]};
        return tmp[8:1];
    endfunction

endpackage

@@ rtl/scpf_in_if.sv @@
interface scpf_in_if import scpf_pkg::*; ();
    logic  valid;
    logic  ready;
    t_axis x_axis;
    t_axis y_axis;
    logic  spring_playing;

    modport source (output valid, output x_axis, output y_axis, output spring_playing,
                    input ready);
    modport sink (input valid, input x_axis, input y_axis, input spring_playing,
                  output ready);
endinterface

@@ rtl/scpf_out_if.sv @@
interface scpf_out_if import scpf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_force force_x;
    t_force force_y;

    modport source (output valid, output force_x, output force_y, input ready);
    modport sink (input valid, input force_x, input force_y, output ready);
endinterface

@@ rtl/scpf_cfg_if.sv @@
interface scpf_cfg_if import scpf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/scpf_lane.sv @@
module scpf_lane import scpf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  t_axis     i_pos,
    input  t_gain     i_spring_gain,
    input  t_gain     i_damping_gain,
    input  t_gain     i_dead_band,
    input  t_gain     i_stiction_offset,
    output t_force    o_force
);

    t_axis r_prev;
    t_vel  r_vel;
    t_vel  r_s1_vel;
    t_vel  r_s1_negpos;
    t_force r_s2_p;
    t_force r_s2_d;

    t_vel              n_vel;
    t_vel              w_diff;
    logic signed [7:0] w_half_diff;
    logic signed [7:0] w_half_vel;
    t_vel              w_negpos;

    // Filtered velocity; the first playing tick sees no position change.
    always_comb begin
        w_diff = i_ctl.seeded ? ({i_pos[7], i_pos} - {r_prev[7], r_prev}) : '0;
    end
    assign w_half_diff = half_tz(w_diff);
    assign w_half_vel  = half_tz(r_vel);
    assign n_vel       = {w_half_diff[7], w_half_diff} + {w_half_vel[7], w_half_vel};
    assign w_negpos    = -$signed({i_pos[7], i_pos});

    // Axis state moves only on a playing transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_vel  <= '0;
        end else if (i_ctl.upd_state) begin
            r_prev <= i_pos;
            r_vel  <= n_vel;
        end
    end

    // First stage register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s1) begin
            r_s1_vel    <= n_vel;
            r_s1_negpos <= w_negpos;
        end
    end

    // Proportional and damping products, scaled toward zero and clamped.
    logic signed [7:0]  w_sg;
    logic signed [7:0]  w_dg;
    logic signed [16:0] w_prod_p;
    logic signed [16:0] w_prod_d;
    logic signed [16:0] w_p_q;
    logic signed [16:0] w_d_q;
    t_force             w_p;
    t_force             w_d;

    assign w_sg     = $signed({1'b0, i_spring_gain});
    assign w_dg     = $signed({1'b0, i_damping_gain});
    assign w_prod_p = r_s1_negpos * w_sg;
    assign w_prod_d = r_s1_vel * w_dg;
    assign w_p_q    = (w_prod_p + (w_prod_p[16] ? 17'sd63 : 17'sd0)) >>> 6;
    assign w_d_q    = (w_prod_d + (w_prod_d[16] ? 17'sd7 : 17'sd0)) >>> 3;

    always_comb begin
        if (w_p_q > P_LIM) begin
            w_p = P_LIM[7:0];
        end else if (w_p_q < -P_LIM) begin
            w_p = 8'(-P_LIM);
        end else begin
            w_p = w_p_q[7:0];
        end
        if (w_d_q > D_LIM) begin
            w_d = D_LIM[7:0];
        end else if (w_d_q < -D_LIM) begin
            w_d = 8'(-D_LIM);
        end else begin
            w_d = w_d_q[7:0];
        end
    end

    // Second stage register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s2) begin
            r_s2_p <= w_p;
            r_s2_d <= w_d;
        end
    end

    // Net force with stiction pushed outside the dead band, then saturated.
    logic signed [9:0] w_f;
    logic signed [9:0] w_db;
    logic signed [9:0] w_so;
    logic signed [9:0] w_fs;

    assign w_f  = {{2{r_s2_p[7]}}, r_s2_p} - {{2{r_s2_d[7]}}, r_s2_d};
    assign w_db = $signed({3'b0, i_dead_band});
    assign w_so = $signed({3'b0, i_stiction_offset});

    always_comb begin
        if (w_f > w_db) begin
            w_fs = w_f + w_so;
        end else if (w_f < -w_db) begin
            w_fs = w_f - w_so;
        end else begin
            w_fs = w_f;
        end
        if (w_fs > F_LIM) begin
            o_force = F_LIM[7:0];
        end else if (w_fs < -F_LIM) begin
            o_force = 8'(-F_LIM);
        end else begin
            o_force = w_fs[7:0];
        end
    end

endmodule

@@ rtl/scpf_merge.sv @@
module scpf_merge import scpf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_play,
    input  t_force     i_force_x,
    input  t_force     i_force_y,
    output logic       o_ready,
    scpf_out_if.source o_out
);

    logic   r_valid;
    t_force r_fx;
    t_force r_fy;

    // The output register takes a new pair whenever it is empty or being drained.
    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Both lanes join into one result; a silent tick drives no force.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_fx <= i_play ? i_force_x : '0;
            r_fy <= i_play ? i_force_y : '0;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.force_x = r_fx;
    assign o_out.force_y = r_fy;

endmodule

@@ rtl/spring_centering_pd_force_unit.sv @@
// Two-axis centering spring with PD control. Each input transfer carries an X/Y stick
// position and a playing flag, and produces exactly one force pair. The pair passes
// through the first stage, second stage and output registers before it is presented.
// One item is accepted every cycle while nothing stalls: the filtered velocity and
// previous-position registers of each axis lane update in the cycle of a playing
// transfer, and the multiplies and saturation follow in later pipeline stages. Stages
// only stall when the output register is full and not being drained. Configuration
// writes are always taken and must only be issued while no item is in flight.
module spring_centering_pd_force_unit import scpf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    scpf_in_if.sink  i_in,
    scpf_cfg_if.sink i_cfg,
    scpf_out_if.source o_out
);

    t_gain r_spring_gain;
    t_gain r_damping_gain;
    t_gain r_dead_band;
    t_gain r_stiction_offset;
    logic  r_seeded;
    logic  r_s1_valid;
    logic  r_s2_valid;
    logic  r_s1_play;
    logic  r_s2_play;

    logic      w_in_acc;
    logic      w_mrg_ready;
    logic      w_s2_move;
    logic      w_s2_load;
    t_lane_ctl w_ctl;
    t_force    w_force_x;
    t_force    w_force_y;

    // Configuration register writes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring_gain     <= SPRING_GAIN_RST;
            r_damping_gain    <= DAMPING_GAIN_RST;
            r_dead_band       <= DEAD_BAND_RST;
            r_stiction_offset <= STICTION_RST;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_SPRING_GAIN:  r_spring_gain     <= i_cfg.data[GainW-1:0];
                REG_DAMPING_GAIN: r_damping_gain    <= i_cfg.data[GainW-1:0];
                REG_DEAD_BAND:    r_dead_band       <= i_cfg.data[GainW-1:0];
                REG_STICTION:     r_stiction_offset <= i_cfg.data[GainW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: each stage moves when the next one has room.
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_s2_move  = r_s2_valid && w_mrg_ready;
    assign w_s2_load  = r_s1_valid && (!r_s2_valid || w_s2_move);
    assign i_in.ready = !r_s1_valid || w_s2_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_seeded   <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (w_in_acc && i_in.spring_playing) begin
                r_seeded <= 1'b1;
            end
        end
    end

    // The playing flag rides along with the lane data.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_play <= i_in.spring_playing;
        end
        if (w_s2_load) begin
            r_s2_play <= r_s1_play;
        end
    end

    assign w_ctl.load_s1   = w_in_acc;
    assign w_ctl.upd_state = w_in_acc && i_in.spring_playing;
    assign w_ctl.seeded    = r_seeded;
    assign w_ctl.load_s2   = w_s2_load;

    // One lane per axis.
    scpf_lane u_lane_x (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .i_pos             (i_in.x_axis),
        .i_spring_gain     (r_spring_gain),
        .i_damping_gain    (r_damping_gain),
        .i_dead_band       (r_dead_band),
        .i_stiction_offset (r_stiction_offset),
        .o_force           (w_force_x)
    );

    scpf_lane u_lane_y (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .i_pos             (i_in.y_axis),
        .i_spring_gain     (r_spring_gain),
        .i_damping_gain    (r_damping_gain),
        .i_dead_band       (r_dead_band),
        .i_stiction_offset (r_stiction_offset),
        .o_force           (w_force_y)
    );

    // Join both lanes into the output register.
    scpf_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s2_valid),
        .i_play    (r_s2_play),
        .i_force_x (w_force_x),
        .i_force_y (w_force_y),
        .o_ready   (w_mrg_ready),
        .o_out     (o_out)
    );

    // A delivered force never reaches the most negative code.
    a_force_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.force_x != 8'sh80) && (o_out.force_y != 8'sh80))
        else $error("force outside saturation range");

    // A playing transfer always leaves the axes seeded.
    a_seed_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.spring_playing) |=> r_seeded)
        else $error("seed flag not set after playing transfer");

    // A silent transfer leaves the seed flag alone.
    a_seed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_in.spring_playing) |=> $stable(r_seeded))
        else $error("seed flag changed on silent transfer");

endmodule

@@ test/spring_force_checker.sv @@
`timescale 1ns / 1ps

// Watches the position, settings and force channels, predicts each force pair
// and compares it with the pair that the unit delivers.
module spring_force_checker import scpf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scpf_in_if         i_in,
    scpf_cfg_if        i_cfg,
    scpf_out_if        i_out,
    output int         o_pending,
    output int         o_errors
);

    localparam int PULL_LIM  = 90;
    localparam int DAMP_LIM  = 127;
    localparam int FORCE_LIM = 127;

    typedef struct packed {
        t_force fx;
        t_force fy;
    } t_force_pair;

    // Shadow copy of the settings registers.
    t_gain spring_gain;
    t_gain damping_gain;
    t_gain dead_band;
    t_gain stiction_offset;

    // Shadow copy of the per-axis filter state.
    t_axis last_x;
    t_axis last_y;
    t_vel  rate_x;
    t_vel  rate_y;
    logic  primed;

    t_force_pair expected_forces[$];
    int          mismatch_total;

    function automatic int clip(input int v, input int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Filtered velocity: both halves truncate toward zero.
    function automatic t_vel next_velocity(input t_axis pos, input t_axis prev_pos,
                                           input t_vel prev_rate);
        int v;
        v = (int'(pos) - int'(prev_pos)) / 2 + int'(prev_rate) / 2;
        return t_vel'(v);
    endfunction

    // Spring pull minus damping, pushed out by the stiction offset past the dead band.
    function automatic t_force spring_force(input t_axis pos, input t_vel rate);
        int pull;
        int damp;
        int f;
        pull = clip(-int'(pos) * int'(spring_gain) / 64, PULL_LIM);
        damp = clip(int'(rate) * int'(damping_gain) / 8, DAMP_LIM);
        f = pull - damp;
        if (f > int'(dead_band)) f = f + int'(stiction_offset);
        if (f < -int'(dead_band)) f = f - int'(stiction_offset);
        return t_force'(clip(f, FORCE_LIM));
    endfunction

    task automatic compare_field(input string name, input t_force want, input t_force got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_vel        vx;
        t_vel        vy;
        t_force_pair pair;
        if (!i_rst_n) begin
            spring_gain     = SPRING_GAIN_RST;
            damping_gain    = DAMPING_GAIN_RST;
            dead_band       = DEAD_BAND_RST;
            stiction_offset = STICTION_RST;
            last_x          = '0;
            last_y          = '0;
            rate_x          = '0;
            rate_y          = '0;
            primed          = 1'b0;
            mismatch_total  = 0;
            expected_forces.delete();
        end else begin
            // Settings writes; unknown indexes are dropped and bit 7 is ignored.
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_SPRING_GAIN:  spring_gain     = i_cfg.data[GainW-1:0];
                    REG_DAMPING_GAIN: damping_gain    = i_cfg.data[GainW-1:0];
                    REG_DEAD_BAND:    dead_band       = i_cfg.data[GainW-1:0];
                    REG_STICTION:     stiction_offset = i_cfg.data[GainW-1:0];
                    default: ;
                endcase
            end

            // Each position transfer yields exactly one force pair.
            if (i_in.valid && i_in.ready) begin
                pair = '0;
                if (i_in.spring_playing) begin
                    // The first playing sample seeds the previous positions.
                    if (!primed) begin
                        last_x = i_in.x_axis;
                        last_y = i_in.y_axis;
                        primed = 1'b1;
                    end
                    vx = next_velocity(i_in.x_axis, last_x, rate_x);
                    vy = next_velocity(i_in.y_axis, last_y, rate_y);
                    pair.fx = spring_force(i_in.x_axis, vx);
                    pair.fy = spring_force(i_in.y_axis, vy);
                    rate_x = vx;
                    rate_y = vy;
                    last_x = i_in.x_axis;
                    last_y = i_in.y_axis;
                end
                expected_forces.push_back(pair);
            end

            // Force transfers are matched against the oldest prediction.
            if (i_out.valid && i_out.ready) begin
                if (expected_forces.size() == 0) begin
                    $display("%0t: unexpected force pair, actual x %0d y %0d",
                             $time, i_out.force_x, i_out.force_y);
                    mismatch_total++;
                end else begin
                    pair = expected_forces.pop_front();
                    compare_field("force_x", pair.fx, i_out.force_x);
                    compare_field("force_y", pair.fy, i_out.force_y);
                end
            end
        end
        o_pending <= expected_forces.size();
        o_errors  <= mismatch_total;
    end

endmodule

@@ test/spring_centering_pd_force_unit_test.sv @@
`timescale 1ns / 1ps

module spring_centering_pd_force_unit_test;
    import scpf_pkg::*;

    localparam int ITEMS_PER_PHASE = 235;
    localparam int PHASES          = 8;
    localparam int LONG_STALL      = 80;
    localparam int STUCK_LIMIT     = 2000;
    localparam int FIRST_UNUSED_IDX = int'(REG_STICTION) + 1;

    logic i_clk;
    logic i_rst_n;

    scpf_in_if  in_ch ();
    scpf_cfg_if cfg_ch ();
    scpf_out_if out_ch ();

    int   pending_results;
    int   error_count;
    int   stuck_cycles;
    int   stall_request;
    int   stall_left;
    bit   calm_src;
    bit   calm_sink;
    t_axis walk_x;
    t_axis walk_y;

    spring_centering_pd_force_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    spring_force_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_cfg     (cfg_ch),
        .i_out     (out_ch),
        .o_pending (pending_results),
        .o_errors  (error_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Force receiver: random back-pressure, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= calm_sink || ($urandom_range(99) >= 18);
        end
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("FAIL spring_centering_pd_force_unit");
            $finish;
        end
    end

    // Offers one position sample, idling at random before it unless calm.
    task automatic send_item(input t_axis x, input t_axis y, input logic playing);
        while (!calm_src && $urandom_range(99) < 18) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.x_axis         <= x;
        in_ch.y_axis         <= y;
        in_ch.spring_playing <= playing;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stops offering and waits until every force pair has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input t_gain value);
        bit junk;
        junk = 1'($urandom_range(1));
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= {junk, value};
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Writes all four settings, then one write to an unused index.
    task automatic load_settings(input t_gain sg, input t_gain dg, input t_gain db,
                                 input t_gain so);
        write_reg(REG_SPRING_GAIN, sg);
        write_reg(REG_DAMPING_GAIN, dg);
        write_reg(REG_DEAD_BAND, db);
        write_reg(REG_STICTION, so);
        write_reg(CfgIdxW'($urandom_range(255, FIRST_UNUSED_IDX)), t_gain'($urandom_range(127)));
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly small moves from the last position, with jumps and extremes mixed in.
    function automatic t_axis next_pos(input t_axis last);
        int pick;
        int p;
        pick = $urandom_range(9);
        if (pick == 0) begin
            case ($urandom_range(3))
                0: p = -128;
                1: p = 127;
                2: p = 0;
                default: p = -1;
            endcase
        end else if (pick <= 3) begin
            p = int'($urandom_range(255)) - 128;
        end else begin
            p = int'(last) + int'($urandom_range(16)) - 8;
            if (p > 127) p = 127;
            if (p < -128) p = -128;
        end
        return t_axis'(p);
    endfunction

    initial begin
        t_axis x;
        t_axis y;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.x_axis         = '0;
        in_ch.y_axis         = '0;
        in_ch.spring_playing = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        out_ch.ready         = 1'b0;
        stuck_cycles         = 0;
        stall_request        = 0;
        stall_left           = 0;
        calm_src             = 1'b0;
        calm_sink            = 1'b0;
        walk_x               = '0;
        walk_y               = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle samples before the spring ever plays leave the filter unseeded.
        send_item(127, -128, 1'b0);
        send_item(-128, 127, 1'b0);
        // The first playing sample seeds the previous positions.
        send_item(100, -100, 1'b1);
        send_item(-128, 127, 1'b1);
        send_item(127, -128, 1'b1);
        send_item(-128, -128, 1'b1);
        send_item(0, 0, 1'b1);
        // An idle sample in mid-run must not disturb the filter.
        send_item(37, -1, 1'b0);
        send_item(-1, 1, 1'b1);
        drain();

        // Pure spring at unit gain: forces land exactly on the dead band and just past it.
        load_settings(64, 0, 10, 60);
        send_item(-10, 10, 1'b1);
        send_item(10, -10, 1'b1);
        send_item(-11, 11, 1'b1);
        send_item(11, -11, 1'b1);
        send_item(0, 0, 1'b1);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_settings(SPRING_GAIN_RST, DAMPING_GAIN_RST, DEAD_BAND_RST, STICTION_RST);
                1: load_settings(0, 0, 0, 0);
                2: load_settings(127, 127, 127, 127);
                3: load_settings(127, 127, 0, 0);
                6: load_settings(0, 127, 127, 127);
                default: load_settings(t_gain'($urandom_range(127)), t_gain'($urandom_range(127)),
                                       t_gain'($urandom_range(127)), t_gain'($urandom_range(127)));
            endcase

            // Long receiver hold-off while samples keep coming, so the pipeline backs up.
            calm_src  = (phase == 4) || (phase == 5);
            calm_sink = (phase == 5);
            if (phase == 4) stall_request = LONG_STALL;

            repeat (ITEMS_PER_PHASE) begin
                x = next_pos(walk_x);
                y = next_pos(walk_y);
                walk_x = x;
                walk_y = y;
                send_item(x, y, $urandom_range(99) < 88);
            end
            drain();
        end

        calm_src  = 1'b0;
        calm_sink = 1'b0;
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_results == 0) begin
            $display("PASS spring_centering_pd_force_unit");
        end else begin
            $display("FAIL spring_centering_pd_force_unit");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/scpf_pkg.sv
rtl/scpf_in_if.sv
rtl/scpf_out_if.sv
rtl/scpf_cfg_if.sv
rtl/scpf_lane.sv
rtl/scpf_merge.sv
rtl/spring_centering_pd_force_unit.sv
test/spring_force_checker.sv
test/spring_centering_pd_force_unit_test.sv
